// ===== rtl/core/carstep_pkg.sv =====
// Package for the cellular automaton row stepper.
// Result word type, queue push bundle, register indexes and size constants.
// No dependencies.
`timescale 1ns / 1ps

package carstep_pkg;

    // Column index width on the result port (index is taken modulo 4096)
    localparam int IDX_W           = 12;
    // Threshold register width
    localparam int THR_W           = 4;
    // Default row length limit
    localparam int MAX_COLUMNS_DEF = 4096;

    // Configuration register indexes
    localparam int          CFG_IDX_W         = 1;
    localparam logic [0:0]  REG_MIN_NEIGHBORS = 1'd0;
    localparam logic [0:0]  REG_MAX_NEIGHBORS = 1'd1;

    localparam logic [THR_W-1:0] MIN_NEIGHBORS_RST = 4'd3;
    localparam logic [THR_W-1:0] MAX_NEIGHBORS_RST = 4'd5;

    // Result queue sizing: up to three words pushed per input word
    localparam int OQ_DEPTH = 4;
    localparam int PUSH_MAX = 3;
    localparam int NUM_W    = 2;

    // Column packing: bit0 upper, bit1 middle, bit2 lower
    typedef logic [2:0] column_t;

    typedef struct packed {
        logic [IDX_W-1:0] column_index;
        logic             alive;
        logic             row_done;
        logic             row_error;
    } result_t;

    typedef struct packed {
        logic [NUM_W-1:0]          num;
        result_t [PUSH_MAX-1:0]    words;
    } push_t;

    typedef struct packed {
        logic room_one;
        logic room_three;
    } oq_status_t;

endpackage

// ===== rtl/core/carstep_cell.sv =====
// Column cell of the window chain: holds one packed column of three cells.
// Depends on carstep_pkg.
`timescale 1ns / 1ps

module carstep_cell
    import carstep_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    clear,
    input  logic    load,
    input  column_t d,
    output column_t q
);

    column_t col_reg;

    // End of row clears, otherwise take the input column d on load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else begin
            priority if (clear) begin
                col_reg <= '0;
            end else if (load) begin
                col_reg <= d;
            end else begin
                col_reg <= col_reg;
            end
        end
    end

    assign q = col_reg;

endmodule

// ===== rtl/core/carstep_rule.sv =====
// Next-state rule for one cell: eight-neighbour count against two thresholds.
// Depends on carstep_pkg.
`timescale 1ns / 1ps

module carstep_rule
    import carstep_pkg::*;
(
    input  column_t           left,
    input  column_t           center,
    input  column_t           right,
    input  logic [THR_W-1:0]  min_neighbors,
    input  logic [THR_W-1:0]  max_neighbors,
    output logic              alive
);

    logic [THR_W-1:0] cnt;

    // Centre column contributes only its upper and lower cells
    always_comb begin
        cnt = THR_W'(left[0]) + THR_W'(left[1]) + THR_W'(left[2])
            + THR_W'(right[0]) + THR_W'(right[1]) + THR_W'(right[2])
            + THR_W'(center[0]) + THR_W'(center[2]);
        alive = (cnt >= min_neighbors) && (cnt <= max_neighbors);
    end

endmodule

// ===== rtl/core/carstep_outq.sv =====
// Result queue: up to three words in per cycle; one out per ready cycle.
// Depends on carstep_pkg.
`timescale 1ns / 1ps

module carstep_outq
    import carstep_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  push_t      push_i,
    output oq_status_t status_o,
    output logic       m_valid,
    input  logic       m_ready,
    output result_t    head_o
);

    localparam int PTR_W = $clog2(OQ_DEPTH);
    localparam int CNT_W = $clog2(OQ_DEPTH + 1);

    result_t          mem_reg [OQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             pop;

    assign pop = m_valid && m_ready;

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_i.num);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_reg + CNT_W'(push_i.num) - CNT_W'(pop);
        end
    end

    // Storage: words land at consecutive slots from the write pointer
    always_ff @(posedge aclk) begin
        for (int k = 0; k < PUSH_MAX; k++) begin
            if (NUM_W'(k) < push_i.num) begin
                mem_reg[wr_ptr_reg + PTR_W'(k)] <= push_i.words[k];
            end
        end
    end

    assign m_valid             = (count_reg != '0);
    assign head_o              = mem_reg[rd_ptr_reg];
    assign status_o.room_one   = (count_reg <= CNT_W'(OQ_DEPTH - 1));
    assign status_o.room_three = (count_reg <= CNT_W'(OQ_DEPTH - PUSH_MAX));

endmodule

// ===== rtl/core/cellular_automaton_row_stepper_top.sv =====
// Top level of the cellular automaton row stepper.
// Depends on carstep_pkg, carstep_cell, carstep_rule and carstep_outq.
//
//   Channel  Direction  Handshake           Payload
//   s_       in         s_valid / s_ready   upper, middle, lower cell, last_column
//   m_       out        m_valid / m_ready   column_index, alive, row_done, row_error
//   cfg_     in         cfg_we              cfg_index, cfg_data (thresholds)
//
// One column word is taken per cycle while s_ready is high; its result is queued in
// the same cycle and shows on m_ behind earlier words. The last column of a row
// pushes three results into the four-word result queue and needs room for all
// three; an error word needs room for one. The first two columns of a row push
// nothing, so with m_ready held high the queue drains and words flow every cycle.
// Input stalls come only from lack of queue room. Reset is synchronous and
// clears the window chain, column count and queue; thresholds go to 3 and 5.
`timescale 1ns / 1ps

module cellular_automaton_row_stepper_top
    import carstep_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]     cfg_data,
    // column words in
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_upper_cell,
    input  logic                 s_middle_cell,
    input  logic                 s_lower_cell,
    input  logic                 s_last_column,
    // result words out
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [IDX_W-1:0]     m_column_index,
    output logic                 m_alive,
    output logic                 m_row_done,
    output logic                 m_row_error
);

    // Count saturates at MAX_COLUMNS + 1
    localparam int CNT_W = $clog2(MAX_COLUMNS + 2);

    logic [THR_W-1:0] min_reg;
    logic [THR_W-1:0] max_reg;
    logic [CNT_W-1:0] seen_reg;
    logic [CNT_W-1:0] seen_next;

    column_t    col_in;
    column_t    first_q, second_q, newer_q, older_q;
    logic       accept;
    logic       in_range;
    logic       row_err;
    logic       row_end;
    logic       alive_mid, alive_last, alive_wrap;
    logic [CNT_W-1:0] seen_m1;
    push_t      push;
    oq_status_t oq_status;
    result_t    head;

    assign col_in   = {s_lower_cell, s_middle_cell, s_upper_cell};
    assign accept   = s_valid && s_ready;
    assign in_range = (seen_reg < CNT_W'(MAX_COLUMNS));
    assign row_err  = (seen_reg < CNT_W'(2)) || !in_range;
    assign row_end  = accept && s_last_column;
    assign seen_m1  = seen_reg - CNT_W'(1);

    // Room for this word's results decides ready
    assign s_ready = (s_last_column && !row_err) ? oq_status.room_three : oq_status.room_one;

    // Threshold registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= MIN_NEIGHBORS_RST;
            max_reg <= MAX_NEIGHBORS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MIN_NEIGHBORS: min_reg <= cfg_data;
                REG_MAX_NEIGHBORS: max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Column count within the row
    always_comb begin
        seen_next = seen_reg;
        if (seen_reg <= CNT_W'(MAX_COLUMNS)) begin
            seen_next = seen_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0;
        end else if (accept) begin
            seen_reg <= s_last_column ? '0 : seen_next;
        end
    end

    // Window chain: input -> newer -> older; first two columns held for wrap
    carstep_cell u_first (
        .aclk(aclk), .aresetn(aresetn), .clear(row_end),
        .load(accept && (seen_reg == '0)), .d(col_in), .q(first_q)
    );

    carstep_cell u_second (
        .aclk(aclk), .aresetn(aresetn), .clear(row_end),
        .load(accept && (seen_reg == CNT_W'(1))), .d(col_in), .q(second_q)
    );

    carstep_cell u_newer (
        .aclk(aclk), .aresetn(aresetn), .clear(row_end),
        .load(accept && in_range), .d(col_in), .q(newer_q)
    );

    carstep_cell u_older (
        .aclk(aclk), .aresetn(aresetn), .clear(row_end),
        .load(accept && in_range), .d(newer_q), .q(older_q)
    );

    // Rules: column n-1, then at row end column n and column 0
    carstep_rule u_rule_mid (
        .left(older_q), .center(newer_q), .right(col_in),
        .min_neighbors(min_reg), .max_neighbors(max_reg), .alive(alive_mid)
    );

    carstep_rule u_rule_last (
        .left(newer_q), .center(col_in), .right(first_q),
        .min_neighbors(min_reg), .max_neighbors(max_reg), .alive(alive_last)
    );

    carstep_rule u_rule_wrap (
        .left(col_in), .center(first_q), .right(second_q),
        .min_neighbors(min_reg), .max_neighbors(max_reg), .alive(alive_wrap)
    );

    // Result words for this input word
    always_comb begin
        push = '0;
        push.words[0].column_index = IDX_W'(seen_m1);
        push.words[0].alive        = alive_mid;
        push.words[1].column_index = IDX_W'(seen_reg);
        push.words[1].alive        = alive_last;
        push.words[2].column_index = '0;
        push.words[2].alive        = alive_wrap;
        push.words[2].row_done     = 1'b1;
        if (accept) begin
            priority if (s_last_column && row_err) begin
                push.num      = NUM_W'(1);
                push.words[0] = '{column_index: '0, alive: 1'b0,
                                  row_done: 1'b1, row_error: 1'b1};
            end else if (s_last_column) begin
                push.num = NUM_W'(PUSH_MAX);
            end else if (!row_err) begin
                push.num = NUM_W'(1);
            end else begin
                push.num = '0;
            end
        end
    end

    carstep_outq u_outq (
        .aclk(aclk), .aresetn(aresetn), .push_i(push), .status_o(oq_status),
        .m_valid(m_valid), .m_ready(m_ready), .head_o(head)
    );

    assign m_column_index = head.column_index;
    assign m_alive        = head.alive;
    assign m_row_done     = head.row_done;
    assign m_row_error    = head.row_error;

endmodule
